[hw/rtl/dhpi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhpi_pkg
// Types and codes shared by the path index front end, job queue and probe engine.
// ----------------------------------------------------------------------------
package dhpi_pkg;

  localparam logic [31:0] HASH1_INIT = 32'd5381;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  path_char;
    logic        last_char;
    logic [31:0] path_offset_in;
    logic [31:0] attr_offset_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] path_offset_out;
    logic [31:0] attr_offset_out;
    logic [9:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic        command;
    logic [31:0] hash1;
    logic [31:0] hash2;
    logic [31:0] path_offset;
    logic [31:0] attr_offset;
  } job_t;

endpackage
`default_nettype wire

[hw/rtl/dhpi_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhpi_front
// Accepts path characters, runs both hashes and emits one job per path.
// ----------------------------------------------------------------------------
module dhpi_front import dhpi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire in_t  in_data,
  input  wire logic hold,
  output logic      full,
  output logic      job_push,
  output job_t      job
);

  logic [31:0] hash1;
  logic [31:0] hash2;
  logic [31:0] hash1_next;
  logic [31:0] hash2_next;
  logic [31:0] ch;
  logic        accept;

  assign ch         = {24'd0, in_data.path_char};
  assign hash1_next = (hash1 << 5) + hash1 + ch;
  assign hash2_next = ch + (hash2 << 6) + (hash2 << 16) - hash2;
  assign full       = hold;
  assign accept     = push && !hold;
  assign job_push   = accept && in_data.last_char;

  assign job.command     = in_data.command;
  assign job.hash1       = hash1_next;
  assign job.hash2       = hash2_next;
  assign job.path_offset = in_data.path_offset_in;
  assign job.attr_offset = in_data.attr_offset_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash1 <= HASH1_INIT;
      hash2 <= 32'd0;
    end else if (accept) begin
      if (in_data.last_char) begin
        hash1 <= HASH1_INIT;
        hash2 <= 32'd0;
      end else begin
        hash1 <= hash1_next;
        hash2 <= hash2_next;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dhpi_job_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhpi_job_fifo
// Two-entry queue of hashed jobs between the front end and the probe engine.
// ----------------------------------------------------------------------------
module dhpi_job_fifo import dhpi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire job_t wr_data,
  input  wire logic rd,
  output job_t      rd_data,
  output logic      fifo_full,
  output logic      fifo_empty
);

  job_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign rd_data    = entries[rptr];
  assign fifo_full  = (fill == 2'd2);
  assign fifo_empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      fill <= fill + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dhpi_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhpi_back
// Probe engine: reduces the hashes modulo the table size, walks the table by
// double hashing, updates it and holds the result for the consumer.
// ----------------------------------------------------------------------------
module dhpi_back import dhpi_pkg::*; #(
  parameter int SLOTS = 1021
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fifo_empty,
  input  wire job_t fifo_data,
  output logic      fifo_pop,
  output logic      clearing,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW:0]   SLOTS_W  = (IW + 1)'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

  // floor(2^SHIFT / SLOTS) fits in 33 bits; the quotient estimate is at most one low
  localparam int          SHIFT   = 32 + IW;
  localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(SLOTS);
  localparam logic [32:0] RECIP   = RECIP64[32:0];

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  typedef struct packed {
    logic        occupied;
    logic [31:0] hash;
    logic [31:0] path_offset;
    logic [31:0] attr_offset;
  } entry_t;

  entry_t mem [SLOTS];
  entry_t rd_entry;
  entry_t wr_entry;
  logic   we;

  logic [2:0]    state;
  job_t          job;
  logic [IW-1:0] idx;
  logic [IW-1:0] step;
  logic [1:0]    mphase;
  logic [64:0]   acc1;
  logic [64:0]   acc2;
  logic [IW:0]   rq1;
  logic [IW:0]   rq2;
  logic [CW-1:0] probes;
  logic [CW-1:0] count;
  out_t          res;
  out_t          out_reg;
  logic          out_valid;

  logic [64:0]   lo1;
  logic [64:0]   lo2;
  logic [64:0]   hi1;
  logic [64:0]   hi2;
  logic [31:0]   q1;
  logic [31:0]   q2;
  logic [31:0]   qd1;
  logic [31:0]   qd2;
  logic [IW:0]   rq1_next;
  logic [IW:0]   rq2_next;
  logic [IW-1:0] rem1_next;
  logic [IW-1:0] rem2_next;
  logic [IW:0]   idx_sum;
  logic [IW-1:0] idx_next;
  logic [CW-1:0] probes_next;
  logic [CW-1:0] count_inc;
  logic [31:0]   idx32;
  logic [31:0]   cnt32;
  logic [31:0]   inc32;
  logic          load_out;
  out_t          early_res;
  out_t          chk_res;
  logic          chk_done;

  // split each 32 x 33 product into two partial products on the 16-bit halves of the hash
  assign lo1 = 65'(49'(job.hash1[15:0]) * 49'(RECIP));
  assign lo2 = 65'(49'(job.hash2[15:0]) * 49'(RECIP));
  assign hi1 = 65'(49'(job.hash1[31:16]) * 49'(RECIP)) << 16;
  assign hi2 = 65'(49'(job.hash2[31:16]) * 49'(RECIP)) << 16;
  assign q1  = 32'(acc1 >> SHIFT);
  assign q2  = 32'(acc2 >> SHIFT);
  assign qd1 = 32'(48'(q1) * 48'(SLOTS));
  assign qd2 = 32'(48'(q2) * 48'(SLOTS));
  assign rq1_next  = (IW + 1)'(job.hash1 - qd1);
  assign rq2_next  = (IW + 1)'(job.hash2 - qd2);
  assign rem1_next = (rq1 >= SLOTS_W) ? IW'(rq1 - SLOTS_W) : rq1[IW-1:0];
  assign rem2_next = (rq2 >= SLOTS_W) ? IW'(rq2 - SLOTS_W) : rq2[IW-1:0];

  assign idx_sum     = {1'b0, idx} + {1'b0, step};
  assign idx_next    = (idx_sum >= SLOTS_W) ? IW'(idx_sum - SLOTS_W) : idx_sum[IW-1:0];
  assign probes_next = probes + CW'(1);
  assign count_inc   = count + CW'(1);
  assign idx32       = 32'(idx);
  assign cnt32       = 32'(count);
  assign inc32       = 32'(count_inc);

  assign clearing = (state == S_CLEAR);
  assign fifo_pop = (state == S_IDLE) && !fifo_empty;
  assign load_out = (state == S_RESULT) && (!out_valid || pop);
  assign empty    = !out_valid;
  assign out_data = out_reg;

  always_comb begin
    early_res             = '0;
    early_res.status      = (fifo_data.command == CMD_INSERT) ? ST_FULL : ST_EMPTY;
    early_res.entry_count = cnt32[9:0];
  end

  always_comb begin
    chk_res             = '0;
    chk_res.entry_count = cnt32[9:0];
    chk_done            = 1'b1;
    if (!rd_entry.occupied) begin
      if (job.command == CMD_INSERT) begin
        chk_res.status      = ST_OK;
        chk_res.slot        = idx32[9:0];
        chk_res.entry_count = inc32[9:0];
      end else begin
        chk_res.status = ST_NOT_FOUND;
      end
    end else if (rd_entry.hash == job.hash1) begin
      chk_res.slot = idx32[9:0];
      if (job.command == CMD_INSERT) begin
        chk_res.status = ST_DUPLICATE;
      end else begin
        chk_res.status          = ST_OK;
        chk_res.path_offset_out = rd_entry.path_offset;
        chk_res.attr_offset_out = rd_entry.attr_offset;
      end
    end else begin
      chk_res.status = (job.command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
      chk_done       = (probes_next == SLOTS_C);
    end
  end

  always_comb begin
    we       = 1'b0;
    wr_entry = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_CHECK && !rd_entry.occupied && job.command == CMD_INSERT) begin
      we                   = 1'b1;
      wr_entry.occupied    = 1'b1;
      wr_entry.hash        = job.hash1;
      wr_entry.path_offset = job.path_offset;
      wr_entry.attr_offset = job.attr_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wr_entry;
    end
    rd_entry <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_IDLE: begin
          if (!fifo_empty) begin
            job    <= fifo_data;
            mphase <= 2'd0;
            res    <= early_res;
            if ((fifo_data.command == CMD_INSERT && count >= SLOTS_C) ||
                (fifo_data.command == CMD_LOOKUP && count == '0)) begin
              state <= S_RESULT;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          mphase <= mphase + 2'd1;
          case (mphase)
            2'd0: begin
              acc1 <= lo1;
              acc2 <= lo2;
            end
            2'd1: begin
              acc1 <= acc1 + hi1;
              acc2 <= acc2 + hi2;
            end
            2'd2: begin
              rq1 <= rq1_next;
              rq2 <= rq2_next;
            end
            default: begin
              idx    <= rem1_next;
              step   <= (rem2_next == '0) ? IW'(1) : rem2_next;
              probes <= '0;
              state  <= S_READ;
            end
          endcase
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (chk_done) begin
            res <= chk_res;
            if (!rd_entry.occupied && job.command == CMD_INSERT) begin
              count <= count_inc;
            end
            state <= S_RESULT;
          end else begin
            idx    <= idx_next;
            probes <= probes_next;
            state  <= S_READ;
          end
        end
        S_RESULT: begin
          if (load_out) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/double_hash_path_index_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_path_index_core
// Path index with double hashing: characters in, one status item per path out.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the two-entry job queue has room.
// With an idle probe engine a final character's job goes from the queue through
// modulo reduction of both hashes, then a table read and a check for each probe.
// A full-table insert or an empty-table lookup skips reduction and probing.
// Reset: synchronous; a clearing pass over all SLOTS entries then empties the table,
// and no character is accepted during it.
module double_hash_path_index_core import dhpi_pkg::*; #(
  parameter int SLOTS = 1021
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_data,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  job_t front_job;
  logic front_push;
  job_t queue_job;
  logic queue_pop;
  logic queue_full;
  logic queue_empty;
  logic clearing;

  dhpi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_data  (in_data),
    .hold     (queue_full || clearing),
    .full     (full),
    .job_push (front_push),
    .job      (front_job)
  );

  dhpi_job_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (front_push),
    .wr_data    (front_job),
    .rd         (queue_pop),
    .rd_data    (queue_job),
    .fifo_full  (queue_full),
    .fifo_empty (queue_empty)
  );

  dhpi_back #(.SLOTS(SLOTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (queue_empty),
    .fifo_data  (queue_job),
    .fifo_pop   (queue_pop),
    .clearing   (clearing),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
